>>> design/mbp_pkg.sv
// Shared types, codes and the status length table of the MIDI byte stream parser.
package mbp_pkg;

  // Longest SysEx kept, counting the opening 0xF0 and the closing 0xF7
  localparam int SYSEX_MAX = 1024;
  localparam int SYSEX_CW  = $clog2(SYSEX_MAX);

  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_STOP   = 8'hF7;

  localparam logic [1:0] KIND_SHORT    = 2'd0;
  localparam logic [1:0] KIND_REALTIME = 2'd1;
  localparam logic [1:0] KIND_SYSEX    = 2'd2;

  // Register index on the configuration port
  localparam logic REG_ENABLED = 1'b0;

  typedef enum logic [1:0] {
    OP_REALTIME,
    OP_STATUS,
    OP_DATA
  } op_class_t;

  typedef struct packed {
    op_class_t   cls;
    logic [7:0]  data;
    logic [1:0]  len;
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [1:0]  len;
    logic        send;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // Message length of a status byte, status included; zero for data bytes and statuses with no short message
  function automatic logic [1:0] status_length(input logic [7:0] status);
    logic [1:0] len;
    if (status < 8'h80) begin
      len = 2'd0;
    end else if (status < 8'hC0) begin
      len = 2'd3;
    end else if (status < 8'hE0) begin
      len = 2'd2;
    end else if (status < 8'hF0) begin
      len = 2'd3;
    end else begin
      case (status[3:0])
        4'h1, 4'h3:                      len = 2'd2;
        4'h2:                            len = 2'd3;
        4'h6, 4'h8, 4'hA, 4'hB, 4'hC,
        4'hE:                            len = 2'd1;
        default:                         len = 2'd0;
      endcase
    end
    return len;
  endfunction

endpackage

>>> design/mbp_front.sv
// Front end: accepts MIDI bytes and classifies them into queued operations.
module mbp_front import mbp_pkg::*; (
  input  logic       enabled,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  q_stat_t    q_stat,
  output logic       full,
  output logic       op_wr,
  output op_t        op
);

  assign full  = q_stat.full;
  // Drop bytes while no device is attached
  assign op_wr = push & ~q_stat.full & enabled;

  always_comb begin
    op.data = in_byte;
    op.len  = 2'd0;
    if (in_byte >= REALTIME_MIN) begin
      op.cls = OP_REALTIME;
    end else if (in_byte[7]) begin
      op.cls = OP_STATUS;
      op.len = status_length(in_byte);
    end else begin
      op.cls = OP_DATA;
    end
  end

endmodule

>>> design/mbp_op_queue.sv
// Two-entry queue of classified operations between front and back ends.
module mbp_op_queue import mbp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  op_t     wdata,
  input  logic    rd,
  output op_t     rdata,
  output q_stat_t stat
);

  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entry[wr_ptr] <= wdata;
  end

  assign rdata      = entry[rd_ptr];
  assign stat.valid = (count != 2'd0);
  assign stat.full  = (count == 2'd2);

endmodule

>>> design/mbp_back.sv
// Back end: running status, SysEx streaming and the result queue.
module mbp_back import mbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  input  op_t  op,
  output logic op_rd,
  input  logic pop,
  output logic empty,
  output res_t head
);

  localparam logic [SYSEX_CW-1:0] SYSEX_LIMIT = SYSEX_CW'(SYSEX_MAX - 1);

  logic [7:0]          running_status, running_status_next;
  logic [1:0]          expected_length, expected_length_next;
  logic [1:0]          bytes_collected, bytes_collected_next;
  logic [7:0]          first_data, first_data_next;
  logic [SYSEX_CW-1:0] sysex_count, sysex_count_next;
  logic                phase, phase_next;

  res_t res_q [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       in_sysex, is_status, has_close, has_second, short_fire;
  logic [7:0] rs_eff;
  logic [1:0] el_eff, bc_eff;
  logic [2:0] pos_inc;
  res_t       second_res, slot0, slot1, cur_res;
  logic       slot0_valid, slot1_valid;
  logic       out_space, res_wr, res_rd;

  always_comb begin
    in_sysex  = (running_status == SYSEX_START);
    is_status = (op.cls == OP_STATUS);

    running_status_next  = running_status;
    expected_length_next = expected_length;
    bytes_collected_next = bytes_collected;
    first_data_next      = first_data;
    sysex_count_next     = sysex_count;

    rs_eff     = is_status ? op.data : running_status;
    el_eff     = is_status ? op.len : expected_length;
    bc_eff     = is_status ? 2'd0 : bytes_collected;
    pos_inc    = {1'b0, bc_eff} + 3'd1;
    short_fire = (el_eff != 2'd0) && (pos_inc >= {1'b0, el_eff});
    has_close  = is_status & in_sysex;
    has_second = 1'b0;
    second_res = '0;

    slot0       = '0;
    slot1       = '0;
    slot0_valid = 1'b0;
    slot1_valid = 1'b0;

    case (op.cls)
      OP_REALTIME: begin
        slot0_valid = 1'b1;
        slot0.kind  = KIND_REALTIME;
        slot0.b0    = op.data;
        slot0.len   = 2'd1;
      end
      OP_STATUS, OP_DATA: begin
        if (!is_status && in_sysex) begin
          // Forward SysEx data until the size limit, then drop silently
          if (sysex_count < SYSEX_LIMIT) begin
            slot0_valid      = 1'b1;
            slot0.kind       = KIND_SYSEX;
            slot0.b0         = op.data;
            slot0.len        = 2'd1;
            sysex_count_next = sysex_count + SYSEX_CW'(1);
          end
        end else begin
          running_status_next  = rs_eff;
          expected_length_next = el_eff;
          bytes_collected_next = bc_eff;
          if (is_status && op.data == SYSEX_START) begin
            has_second       = 1'b1;
            second_res.kind  = KIND_SYSEX;
            second_res.b0    = SYSEX_START;
            second_res.len   = 2'd1;
            sysex_count_next = SYSEX_CW'(1);
          end
          if (el_eff != 2'd0) begin
            if (bc_eff == 2'd1) first_data_next = op.data;
            bytes_collected_next = short_fire ? 2'd1 : pos_inc[1:0];
            if (short_fire) begin
              has_second      = 1'b1;
              second_res.kind = KIND_SHORT;
              second_res.b0   = rs_eff;
              second_res.len  = el_eff;
              if (el_eff == 2'd2) second_res.b1 = op.data;
              if (el_eff == 2'd3) begin
                second_res.b1 = first_data;
                second_res.b2 = op.data;
              end
            end
          end
          if (has_close) begin
            slot0_valid = 1'b1;
            slot0.kind  = KIND_SYSEX;
            slot0.b0    = SYSEX_STOP;
            slot0.len   = 2'd1;
            slot0.send  = 1'b1;
            slot1_valid = has_second;
            slot1       = second_res;
          end else begin
            slot0_valid = has_second;
            slot0       = second_res;
          end
        end
      end
      default: begin
        slot0_valid = 1'b0;
      end
    endcase
  end

  // A byte with two results writes them into the result queue one after the other, slot0 first
  assign out_space = (count != 3'd4);
  assign res_wr    = op_valid & slot0_valid & out_space;
  assign op_rd     = op_valid & (~slot0_valid | (out_space & (phase | ~slot1_valid)));
  assign res_rd    = pop & ~empty;

  always_comb begin
    cur_res      = phase ? slot1 : slot0;
    cur_res.last = phase | ~slot1_valid;
    phase_next   = phase;
    if (res_wr && !phase && slot1_valid) begin
      phase_next = 1'b1;
    end else if (op_rd) begin
      phase_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= 8'd0;
      expected_length <= 2'd0;
      bytes_collected <= 2'd0;
      first_data      <= 8'd0;
      sysex_count     <= '0;
      phase           <= 1'b0;
    end else begin
      phase <= phase_next;
      if (op_rd) begin
        running_status  <= running_status_next;
        expected_length <= expected_length_next;
        bytes_collected <= bytes_collected_next;
        first_data      <= first_data_next;
        sysex_count     <= sysex_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (res_wr) wr_ptr <= wr_ptr + 2'd1;
      if (res_rd) rd_ptr <= rd_ptr + 2'd1;
      case ({res_wr, res_rd})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) res_q[wr_ptr] <= cur_res;
  end

  assign empty = (count == 3'd0);
  assign head  = res_q[rd_ptr];

endmodule

>>> design/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser: configuration port and front/back wiring.
//
// Bytes enter through a push/full queue interface and complete messages leave through an
// empty/pop interface. Realtime bytes (0xF8 and above) come out at once as one-byte results;
// status bytes set the running status and the expected length, and data bytes complete short
// messages under that running status, system-common statuses included. A SysEx is streamed one
// result per byte, starting with the 0xF0, dropping data beyond the size limit, and closed by an
// appended 0xF7 (sysex_end high) when the next status byte arrives; that status byte is then
// handled as a status byte. The field last marks the final result that a byte causes. While the
// enabled register (byte address 0, bit 0) is zero every byte is taken and ignored. A byte is
// accepted every cycle while full is low; a byte that causes two results (a SysEx close
// followed by a new message) writes them one after the other through the single write port
// of the four-entry result queue; the two-entry operation queue between the classifier and
// the back end holds the next byte meanwhile, so the input side stalls. A pushed byte is
// registered in the operation queue, and its result in the result queue, before the ports.
module midi_byte_stream_parser import mbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  kind,
  output logic [7:0]  byte0,
  output logic [7:0]  byte1,
  output logic [7:0]  byte2,
  output logic [1:0]  msg_length,
  output logic        sysex_end,
  output logic        last
);

  logic    enabled;
  logic    cfg_wr;
  logic    op_wr;
  logic    op_rd;
  op_t     op_in;
  op_t     op_head;
  q_stat_t q_stat;
  res_t    head;

  // Register file: a single enable bit, written at the access beat
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_ENABLED) begin
      enabled <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_ENABLED) prdata = {31'd0, enabled};
  end

  // Classify each accepted byte
  mbp_front u_front (
    .enabled (enabled),
    .push    (push),
    .in_byte (in_byte),
    .q_stat  (q_stat),
    .full    (full),
    .op_wr   (op_wr),
    .op      (op_in)
  );

  // Hold classified bytes so either side can stall
  mbp_op_queue u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (op_wr),
    .wdata (op_in),
    .rd    (op_rd),
    .rdata (op_head),
    .stat  (q_stat)
  );

  // Advance the parser state and emit result beats
  mbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_stat.valid),
    .op       (op_head),
    .op_rd    (op_rd),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign kind       = head.kind;
  assign byte0      = head.b0;
  assign byte1      = head.b1;
  assign byte2      = head.b2;
  assign msg_length = head.len;
  assign sysex_end  = head.send;
  assign last       = head.last;

  // The back end never takes an operation from an empty queue
  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst) op_rd |-> q_stat.valid)
    else $error("operation taken from empty queue");

  // Nothing is queued while no device is attached
  a_wr_enabled: assert property (@(posedge clk) disable iff (rst) op_wr |-> enabled)
    else $error("byte queued while disabled");

  // Every accepted beat while enabled reaches the operation queue
  a_beat_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full && enabled) |-> op_wr)
    else $error("accepted byte lost before queue");

  // Result side is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("results pending after reset");

endmodule

>>> tb/midi_byte_stream_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the MIDI byte stream parser.
module midi_byte_stream_parser_test;
  import mbp_pkg::*;

  // Cycles to let the pipeline settle once nothing is expected.
  localparam int SETTLE_CYCLES = 10;
  // Hard stop, far above the slowest legal run.
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [2:0] ENABLE_ADDR = 3'(4 * int'(REG_ENABLED));

  // Low four bits of a system status select its message length.
  localparam logic [15:0][1:0] SYSTEM_LEN = {
    2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1,
    2'd0, 2'd1, 2'd0, 2'd0, 2'd2, 2'd3, 2'd2, 2'd0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
    logic       sx_end;
    logic       last;
  } midi_msg_t;

  // One row of the directed table: the byte, and where the answer is obvious,
  // the typed-in result (or the fact that there is none).
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic       has_msg;
    midi_msg_t  msg;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [1:0]  kind;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [1:0]  msg_length;
  logic        sysex_end;
  logic        last;

  midi_byte_stream_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .byte0      (byte0),
    .byte1      (byte1),
    .byte2      (byte2),
    .msg_length (msg_length),
    .sysex_end  (sysex_end),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state mirrored by the predictor
  logic        cfg_enabled;
  logic [7:0]  cur_status;
  logic [1:0]  need_len;
  logic [1:0]  got_len;
  logic [7:0]  first_data;
  logic [10:0] sx_count;

  midi_msg_t   pending_msgs[$];   // results still owed by the block, oldest first
  logic [7:0]  tx_bytes[$];       // bytes waiting to be sent
  stim_row_t   directed_rows[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [1:0] msg_size(input logic [7:0] s);
    if (!s[7]) return 2'd0;
    if (s[7:4] != 4'hF) return (s[7:5] == 3'b110) ? 2'd2 : 2'd3;
    return SYSTEM_LEN[s[3:0]];
  endfunction

  function automatic midi_msg_t mk_msg(input logic [1:0] k, input logic [7:0] b0,
                                       input logic [7:0] b1, input logic [7:0] b2,
                                       input logic [1:0] len, input logic sx_end);
    midi_msg_t m;
    m.kind   = k;
    m.b0     = b0;
    m.b1     = b1;
    m.b2     = b2;
    m.len    = len;
    m.sx_end = sx_end;
    m.last   = 1'b0;
    return m;
  endfunction

  // Advance the mirrored state by one accepted byte and queue what it yields.
  function automatic void decode_byte(input logic [7:0] b);
    int         n0;
    logic [1:0] pos;
    logic [7:0] d1;
    logic [7:0] d2;
    n0 = pending_msgs.size();
    if (!cfg_enabled) return;
    if (b >= REALTIME_MIN) begin
      // Realtime passes straight through and leaves the state alone
      pending_msgs.push_back(mk_msg(KIND_REALTIME, b, 8'h00, 8'h00, 2'd1, 1'b0));
    end else if (cur_status == SYSEX_START && !b[7]) begin
      // SysEx data: forward until the size limit, then drop silently
      if (sx_count < 11'(SYSEX_MAX - 1)) begin
        pending_msgs.push_back(mk_msg(KIND_SYSEX, b, 8'h00, 8'h00, 2'd1, 1'b0));
        sx_count = sx_count + 11'd1;
      end
    end else begin
      // Any status byte closes an open SysEx before it is handled itself
      if (cur_status == SYSEX_START)
        pending_msgs.push_back(mk_msg(KIND_SYSEX, SYSEX_STOP, 8'h00, 8'h00, 2'd1, 1'b1));
      if (b[7]) begin
        cur_status = b;
        got_len    = 2'd0;
        need_len   = msg_size(b);
        if (b == SYSEX_START) begin
          pending_msgs.push_back(mk_msg(KIND_SYSEX, SYSEX_START, 8'h00, 8'h00, 2'd1, 1'b0));
          sx_count = 11'd1;
        end
      end
      if (need_len != 2'd0) begin
        pos = got_len;
        d1  = 8'h00;
        d2  = 8'h00;
        if (pos == 2'd1) first_data = b;
        pos = pos + 2'd1;
        if (pos >= need_len) begin
          if (need_len >= 2'd2) d1 = (need_len == 2'd2) ? b : first_data;
          if (need_len == 2'd3) d2 = b;
          pending_msgs.push_back(mk_msg(KIND_SHORT, cur_status, d1, d2, need_len, 1'b0));
          pos = 2'd1;   // running status: next data byte starts a new message
        end
        got_len = pos;
      end
    end
    if (pending_msgs.size() > n0) pending_msgs[pending_msgs.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one register through a setup and an access cycle.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ENABLE_ADDR) cfg_enabled = value[0];
  endtask

  // Offer one byte and hold it until a beat is taken. Bursts of random length
  // are separated by random gaps; roughly one burst in four has no gap at all.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push    <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    burst_left--;
  endtask

  task automatic send_queued();
    logic [7:0] b;
    while (tx_bytes.size() > 0) begin
      b = tx_bytes.pop_front();
      send_byte(b);
      decode_byte(b);
    end
    push <= 1'b0;
  endtask

  // Hold until every expected result has come back, then let the pipe settle.
  task automatic wait_drained();
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Queue a byte, now and then preceded by a realtime byte.
  task automatic add_byte(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) tx_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    tx_bytes.push_back(b);
  endtask

  task automatic add_data(input int count);
    for (int i = 0; i < count; i++) add_byte(8'($urandom_range(0, 127)));
  endtask

  // Mostly well-formed messages with random content; the rest is running
  // status, broken messages and plain noise.
  task automatic queue_phrase();
    int         pick;
    int         dlen;
    logic [7:0] st;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      st = 8'($urandom_range(8'h80, 8'hEF));
      add_byte(st);
      dlen = int'(msg_size(st)) - 1;
      if ($urandom_range(0, 7) == 0) add_data($urandom_range(0, 4));
      else add_data(dlen * $urandom_range(1, 3));
    end else if (pick < 50) begin
      add_data($urandom_range(1, 4));
    end else if (pick < 60) begin
      st = ($urandom_range(0, 3) == 0) ? 8'hF6 : 8'hF0 + 8'($urandom_range(1, 3));
      add_byte(st);
      dlen = int'(msg_size(st)) - 1;
      add_data(dlen * $urandom_range(1, 2) + $urandom_range(0, 1));
    end else if (pick < 75) begin
      add_byte(SYSEX_START);
      add_data($urandom_range(0, 12));
      if ($urandom_range(0, 1) == 0) add_byte(SYSEX_STOP);
      else add_byte(8'($urandom_range(8'h80, 8'hF7)));
    end else if (pick < 85) begin
      tx_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end else if (pick < 92) begin
      st = 8'hF4 + 8'($urandom_range(0, 1));
      add_byte(($urandom_range(0, 2) == 0) ? SYSEX_STOP : st);
      add_data($urandom_range(0, 3));
    end else begin
      for (int i = $urandom_range(1, 3); i > 0; i--)
        tx_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_random(input int count);
    while (tx_bytes.size() < count) queue_phrase();
  endtask

  task automatic add_row(input logic [7:0] data, input logic typed, input logic has_msg,
                         input midi_msg_t msg);
    stim_row_t r;
    r.data    = data;
    r.typed   = typed;
    r.has_msg = has_msg;
    r.msg     = msg;
    r.msg.last = 1'b1;
    directed_rows.push_back(r);
  endtask

  task automatic build_directed();
    midi_msg_t none;
    none = '0;
    // Data byte straight after reset has no status to attach to
    add_row(8'h45, 1'b1, 1'b0, none);
    // Realtime extremes
    add_row(8'hFF, 1'b1, 1'b1, mk_msg(KIND_REALTIME, 8'hFF, 8'h00, 8'h00, 2'd1, 1'b0));
    add_row(8'hF8, 1'b1, 1'b1, mk_msg(KIND_REALTIME, 8'hF8, 8'h00, 8'h00, 2'd1, 1'b0));
    // Three-byte channel message, then a two-byte one
    add_row(8'h90, 1'b0, 1'b0, none);
    add_row(8'h3C, 1'b0, 1'b0, none);
    add_row(8'h7F, 1'b0, 1'b0, none);
    add_row(8'hC5, 1'b0, 1'b0, none);
    add_row(8'h7F, 1'b0, 1'b0, none);
    // One-byte status repeats under running status and swallows the data
    add_row(8'hF6, 1'b1, 1'b1, mk_msg(KIND_SHORT, 8'hF6, 8'h00, 8'h00, 2'd1, 1'b0));
    add_row(8'h12, 1'b1, 1'b1, mk_msg(KIND_SHORT, 8'hF6, 8'h00, 8'h00, 2'd1, 1'b0));
    // Undefined status: following data is ignored
    add_row(8'hF4, 1'b1, 1'b0, none);
    add_row(8'h33, 1'b1, 1'b0, none);
    // Three-byte system common message
    add_row(8'hF2, 1'b0, 1'b0, none);
    add_row(8'h01, 1'b0, 1'b0, none);
    add_row(8'h02, 1'b0, 1'b0, none);
    // SysEx start, data, realtime inside, closed by an incoming 0xF7
    add_row(8'hF0, 1'b1, 1'b1, mk_msg(KIND_SYSEX, 8'hF0, 8'h00, 8'h00, 2'd1, 1'b0));
    add_row(8'h7F, 1'b1, 1'b1, mk_msg(KIND_SYSEX, 8'h7F, 8'h00, 8'h00, 2'd1, 1'b0));
    add_row(8'hF9, 1'b1, 1'b1, mk_msg(KIND_REALTIME, 8'hF9, 8'h00, 8'h00, 2'd1, 1'b0));
    add_row(8'h00, 1'b0, 1'b0, none);
    add_row(8'hF7, 1'b1, 1'b1, mk_msg(KIND_SYSEX, 8'hF7, 8'h00, 8'h00, 2'd1, 1'b1));
    // SysEx closed by a one-byte status: two results from one byte
    add_row(8'hF0, 1'b0, 1'b0, none);
    add_row(8'hF6, 1'b0, 1'b0, none);
    // Pitch bend with a zero second data byte
    add_row(8'hE3, 1'b0, 1'b0, none);
    add_row(8'h7F, 1'b0, 1'b0, none);
    add_row(8'h00, 1'b0, 1'b0, none);
  endtask

  // Walk the table; typed rows replace what the predictor queued.
  task automatic run_directed();
    int n0;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data);
      n0 = pending_msgs.size();
      decode_byte(directed_rows[i].data);
      if (directed_rows[i].typed) begin
        while (pending_msgs.size() > n0) void'(pending_msgs.pop_back());
        if (directed_rows[i].has_msg) pending_msgs.push_back(directed_rows[i].msg);
      end
    end
    push <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  task automatic check_beat();
    midi_msg_t want;
    if (pending_msgs.size() == 0) begin
      $error("result with none expected: kind %0d byte0 %h", kind, byte0);
      fail_count++;
    end else begin
      want = pending_msgs.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        fail_count++;
      end
      if (byte0 !== want.b0) begin
        $error("byte0: expected %h, got %h", want.b0, byte0);
        fail_count++;
      end
      if (byte1 !== want.b1) begin
        $error("byte1: expected %h, got %h", want.b1, byte1);
        fail_count++;
      end
      if (byte2 !== want.b2) begin
        $error("byte2: expected %h, got %h", want.b2, byte2);
        fail_count++;
      end
      if (msg_length !== want.len) begin
        $error("msg_length: expected %0d, got %0d", want.len, msg_length);
        fail_count++;
      end
      if (sysex_end !== want.sx_end) begin
        $error("sysex_end: expected %0d, got %0d", want.sx_end, sysex_end);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        fail_count++;
      end
    end
  endtask

  int stall_mode = 0;
  int stall_left = 0;

  // Check every popped beat, then pick pop for the next edge. The pattern
  // switches between free flow, coin flips, rare pops and long stalls.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_beat();
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= ($urandom_range(0, 1) == 1);
        2:       pop <= ($urandom_range(0, 7) == 0);
        default: pop <= (stall_left % 20 < 3);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    cfg_enabled = 1'b0;
    cur_status  = 8'h00;
    need_len    = 2'd0;
    got_len     = 2'd0;
    first_data  = 8'h00;
    sx_count    = 11'd0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_reg(ENABLE_ADDR, 32'd1);
    build_directed();
    run_directed();

    // Hold the sender until the block has nothing left to give
    wait_drained();
    queue_random(40);
    send_queued();

    // Detach the device: every byte is taken and dropped, state is kept
    wait_drained();
    write_reg(ENABLE_ADDR, 32'd0);
    repeat (16) tx_bytes.push_back(8'($urandom_range(0, 255)));
    send_queued();
    wait_drained();
    write_reg(ENABLE_ADDR, 32'd1);

    queue_random(30);
    send_queued();

    // Oversized SysEx: data beyond the limit is dropped, then closed by a status
    tx_bytes.push_back(SYSEX_START);
    for (int i = 0; i < SYSEX_MAX + 4; i++) tx_bytes.push_back(8'($urandom_range(0, 127)));
    tx_bytes.push_back(8'h90);
    send_queued();

    queue_random(10);
    send_queued();

    wait_drained();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/mbp_pkg.sv
design/mbp_front.sv
design/mbp_op_queue.sv
design/mbp_back.sv
design/midi_byte_stream_parser.sv
tb/midi_byte_stream_parser_test.sv
